@@ sv/tcs_pkg.sv @@
package tcs_pkg;

  // Default precision of relative luminance, fraction bits
  localparam int unsigned LUMA_FRAC_BITS_DEF = 16;

  // Fixed widths
  localparam int unsigned CH_W     = 8;   // colour channel
  localparam int unsigned RGB_W    = 3 * CH_W;
  localparam int unsigned LIN_W    = 25;  // linear channel, Q0.24 up to exactly 1.0
  localparam int unsigned SUM_W    = 38;  // weighted sum, 10000 * 2^24 fits
  localparam int unsigned RATIO_W  = 13;  // min_ratio, Q5.8
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned SRC_W    = 2;

  // Luminance weights, scaled by 10000
  localparam int unsigned COEF_R = 2126;
  localparam int unsigned COEF_G = 7152;
  localparam int unsigned COEF_B = 722;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_RGB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_RGB  = 2'd2;

  // Register reset values
  localparam logic [RATIO_W-1:0] MIN_RATIO_RST = 13'd1152;
  localparam logic [RGB_W-1:0]   LIGHT_RGB_RST = 24'hFFFFFF;
  localparam logic [RGB_W-1:0]   DARK_RGB_RST  = 24'h000000;

  // Source codes of the chosen colour
  localparam logic [SRC_W-1:0] SRC_PREFERRED = 2'd0;
  localparam logic [SRC_W-1:0] SRC_LIGHT     = 2'd1;
  localparam logic [SRC_W-1:0] SRC_DARK      = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] preferred_red;
    logic [CH_W-1:0] preferred_green;
    logic [CH_W-1:0] preferred_blue;
    logic [CH_W-1:0] back_red;
    logic [CH_W-1:0] back_green;
    logic [CH_W-1:0] back_blue;
  } tcs_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  chosen_red;
    logic [CH_W-1:0]  chosen_green;
    logic [CH_W-1:0]  chosen_blue;
    logic [SRC_W-1:0] chosen_source;
  } tcs_out_t;

  // Load enables of the three luminance stages
  typedef struct packed {
    logic lookup;
    logic sum;
    logic scale;
  } tcs_lum_en_t;

  typedef logic [255:0][LIN_W-1:0] tcs_lin_tab_t;

  // Truncated fifth power in Q0.32
  function automatic logic [63:0] fifth_q32(input logic [63:0] r);
    logic [63:0] p2;
    logic [63:0] p4;
    p2 = (r * r) >> 32;
    p4 = (p2 * p2) >> 32;
    return (p4 * r) >> 32;
  endfunction

  // sRGB transfer curve at code c, Q0.24
  function automatic logic [LIN_W-1:0] lin_q24(input int unsigned c);
    logic [63:0] cc;
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] lin32;
    cc = 64'(c & 32'hFF);
    if (cc <= 64'd10) begin
      return LIN_W'((((cc * 64'd100) << 24) + 64'd164730) / 64'd329460);
    end
    if (cc == 64'd255) begin
      return LIN_W'(64'd1 << 24);
    end
    v  = (((cc * 64'd1000 + 64'd14025) << 32) + 64'd134512) / 64'd269025;
    v2 = (v * v) >> 32;
    r  = 64'd0;
    // fifth root by bit search: v^2.4 = v^2 * v^0.4
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (fifth_q32(t) <= v2) begin
        r = t;
      end
    end
    lin32 = (v2 * r) >> 32;
    return LIN_W'((lin32 + 64'd128) >> 8);
  endfunction

  function automatic tcs_lin_tab_t build_lin_table();
    tcs_lin_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = lin_q24(i);
    end
    return tab;
  endfunction

  localparam tcs_lin_tab_t LIN_TABLE = build_lin_table();

endpackage

@@ sv/text_contrast_selector_top.sv @@
// Text contrast selector.
// Input channel: in_valid / in_stall with in_data holding the preferred text
// colour and the background colour. Output channel: out_valid / out_stall with
// out_data holding the colour to draw text in and where it came from
// (preferred, light fallback or dark fallback). A transfer happens on a clock
// edge with valid high and stall low.
// Configuration: cfg_we, cfg_index, cfg_data; writes take effect on the next
// edge and should be made while no item is in flight.
// An accepted item is registered in each stage in turn; out_valid shows it
// in the last. One item is accepted every cycle unless in_stall is high;
// the six stages are lookup, weighted sum, reciprocal scale, ratio terms,
// cross products, compare and select.
// out_stall holds the full stages downstream of the last empty one; others fill,
// so in_stall rises only when all six stages hold an item and the output waits.
// Reset (rst_n low, synchronous) empties the pipeline and returns the
// registers to 4.5:1, white light fallback and black dark fallback.
module text_contrast_selector_top #(
  parameter int unsigned LUMA_FRAC_BITS = tcs_pkg::LUMA_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tcs_pkg::tcs_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tcs_pkg::tcs_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned NSTG = 6;
  localparam int unsigned LW   = LUMA_FRAC_BITS + 1;
  localparam logic [LW-1:0] OFF = LW'(((64'd1 << LUMA_FRAC_BITS) + 64'd10) / 64'd20);
  localparam int unsigned PN_W = LW + tcs_pkg::RATIO_W;
  localparam int unsigned FB_W = 2 * LW;

  // configuration registers
  logic [tcs_pkg::RATIO_W-1:0] min_ratio_r, min_ratio_nxt;
  logic [tcs_pkg::RGB_W-1:0]   light_r, light_nxt;
  logic [tcs_pkg::RGB_W-1:0]   dark_r, dark_nxt;

  // pipeline control
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] en;
  tcs_pkg::tcs_lum_en_t lum_en;

  // preferred colour carried alongside, stages 1 to 5
  logic [tcs_pkg::RGB_W-1:0] pref_r [NSTG-1];
  logic [tcs_pkg::RGB_W-1:0] pref_in;

  // luminances out of stage 3
  logic [LW-1:0] lum_pref, lum_back, lum_light, lum_dark;

  // stage 4: ratio terms
  logic [LW-1:0] p_num_r, p_den_r, l_num_r, l_den_r, d_num_r, d_den_r;
  logic [LW-1:0] p_num_nxt, p_den_nxt, l_num_nxt, l_den_nxt, d_num_nxt, d_den_nxt;

  // stage 5: cross products
  logic [PN_W-1:0] pass_lhs_r, pass_rhs_r, pass_lhs_nxt, pass_rhs_nxt;
  logic [FB_W-1:0] light_x_r, dark_x_r, light_x_nxt, dark_x_nxt;

  // stage 6: output register
  tcs_pkg::tcs_out_t out_r, out_nxt;

  // register writes; index three is ignored
  always_comb begin
    min_ratio_nxt = min_ratio_r;
    light_nxt     = light_r;
    dark_nxt      = dark_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tcs_pkg::REG_MIN_RATIO: min_ratio_nxt = cfg_data[tcs_pkg::RATIO_W-1:0];
        tcs_pkg::REG_LIGHT_RGB: light_nxt     = cfg_data[tcs_pkg::RGB_W-1:0];
        tcs_pkg::REG_DARK_RGB:  dark_nxt      = cfg_data[tcs_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ratio_r <= tcs_pkg::MIN_RATIO_RST;
      light_r     <= tcs_pkg::LIGHT_RGB_RST;
      dark_r      <= tcs_pkg::DARK_RGB_RST;
    end else begin
      min_ratio_r <= min_ratio_nxt;
      light_r     <= light_nxt;
      dark_r      <= dark_nxt;
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
    lum_en.lookup = en[0];
    lum_en.sum    = en[1];
    lum_en.scale  = en[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !en[0];

  // luminance pipes for the four colours
  tcs_luma #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_luma_pref (
    .clk   (clk),
    .en    (lum_en),
    .red   (in_data.preferred_red),
    .green (in_data.preferred_green),
    .blue  (in_data.preferred_blue),
    .luma  (lum_pref)
  );

  tcs_luma #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_luma_back (
    .clk   (clk),
    .en    (lum_en),
    .red   (in_data.back_red),
    .green (in_data.back_green),
    .blue  (in_data.back_blue),
    .luma  (lum_back)
  );

  tcs_luma #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_luma_light (
    .clk   (clk),
    .en    (lum_en),
    .red   (light_r[23:16]),
    .green (light_r[15:8]),
    .blue  (light_r[7:0]),
    .luma  (lum_light)
  );

  tcs_luma #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_luma_dark (
    .clk   (clk),
    .en    (lum_en),
    .red   (dark_r[23:16]),
    .green (dark_r[15:8]),
    .blue  (dark_r[7:0]),
    .luma  (lum_dark)
  );

  // preferred colour delay line
  assign pref_in = {in_data.preferred_red, in_data.preferred_green, in_data.preferred_blue};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pref_r[0] <= pref_in;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) begin
        pref_r[k] <= pref_r[k-1];
      end
    end
  end

  // stage 4: lighter and darker terms, each offset by 0.05
  always_comb begin
    if (lum_pref >= lum_back) begin
      p_num_nxt = lum_pref + OFF;
      p_den_nxt = lum_back + OFF;
    end else begin
      p_num_nxt = lum_back + OFF;
      p_den_nxt = lum_pref + OFF;
    end
    if (lum_light >= lum_back) begin
      l_num_nxt = lum_light + OFF;
      l_den_nxt = lum_back + OFF;
    end else begin
      l_num_nxt = lum_back + OFF;
      l_den_nxt = lum_light + OFF;
    end
    if (lum_dark >= lum_back) begin
      d_num_nxt = lum_dark + OFF;
      d_den_nxt = lum_back + OFF;
    end else begin
      d_num_nxt = lum_back + OFF;
      d_den_nxt = lum_dark + OFF;
    end
  end

  // stage 5: cross products replace the divisions
  always_comb begin
    pass_lhs_nxt = PN_W'(p_num_r) << 8;
    pass_rhs_nxt = PN_W'(min_ratio_r) * PN_W'(p_den_r);
    light_x_nxt  = FB_W'(l_num_r) * FB_W'(d_den_r);
    dark_x_nxt   = FB_W'(d_num_r) * FB_W'(l_den_r);
  end

  // stage 6: keep preferred if it passes, else the better fallback; tie to light
  always_comb begin
    if (pass_lhs_r >= pass_rhs_r) begin
      out_nxt.chosen_red    = pref_r[NSTG-2][23:16];
      out_nxt.chosen_green  = pref_r[NSTG-2][15:8];
      out_nxt.chosen_blue   = pref_r[NSTG-2][7:0];
      out_nxt.chosen_source = tcs_pkg::SRC_PREFERRED;
    end else if (light_x_r >= dark_x_r) begin
      out_nxt.chosen_red    = light_r[23:16];
      out_nxt.chosen_green  = light_r[15:8];
      out_nxt.chosen_blue   = light_r[7:0];
      out_nxt.chosen_source = tcs_pkg::SRC_LIGHT;
    end else begin
      out_nxt.chosen_red    = dark_r[23:16];
      out_nxt.chosen_green  = dark_r[15:8];
      out_nxt.chosen_blue   = dark_r[7:0];
      out_nxt.chosen_source = tcs_pkg::SRC_DARK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p_num_r <= p_num_nxt;
      p_den_r <= p_den_nxt;
      l_num_r <= l_num_nxt;
      l_den_r <= l_den_nxt;
      d_num_r <= d_num_nxt;
      d_den_r <= d_den_nxt;
    end
    if (en[4]) begin
      pass_lhs_r <= pass_lhs_nxt;
      pass_rhs_r <= pass_rhs_nxt;
      light_x_r  <= light_x_nxt;
      dark_x_r   <= dark_x_nxt;
    end
    if (en[5]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

  // input is held back only with every stage full and the output waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&vld_r) && out_stall))
    else $error("input stalled with room in the pipeline");

  // a transfer in always lands in the first stage
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted item missing from first stage");

  // with the output free, the last stage follows the one before it
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |=> (out_valid == $past(vld_r[NSTG-2])))
    else $error("output valid out of step with stage five");

endmodule

@@ sv/tcs_luma.sv @@
// Relative luminance of one colour, three pipeline stages:
// table lookup, weighted sum with rounding shift, reciprocal scale by 1/625.
module tcs_luma #(
  parameter int unsigned LUMA_FRAC_BITS = tcs_pkg::LUMA_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  tcs_pkg::tcs_lum_en_t              en,
  input  logic [tcs_pkg::CH_W-1:0]          red,
  input  logic [tcs_pkg::CH_W-1:0]          green,
  input  logic [tcs_pkg::CH_W-1:0]          blue,
  output logic [LUMA_FRAC_BITS:0]           luma
);

  localparam int unsigned LW    = LUMA_FRAC_BITS + 1;
  localparam int unsigned K     = 24 - LUMA_FRAC_BITS;
  // divisor 10000 * 2^K = 625 * 2^(K+4)
  localparam int unsigned SHIFT = K + 4;
  localparam logic [tcs_pkg::SUM_W-1:0] HALF = tcs_pkg::SUM_W'(5000) << K;
  // scaled sum stays below 625 * 2^F + 313
  localparam int unsigned N     = LUMA_FRAC_BITS + 10;
  localparam int unsigned S     = N + 10;
  localparam logic [63:0] RECIP = ((64'd1 << S) + 64'd624) / 64'd625;
  localparam int unsigned P_W   = 2 * N + 1;

  logic [tcs_pkg::LIN_W-1:0] lin_r_r, lin_g_r, lin_b_r;
  logic [tcs_pkg::LIN_W-1:0] lin_r_nxt, lin_g_nxt, lin_b_nxt;
  logic [tcs_pkg::SUM_W-1:0] sum;
  logic [tcs_pkg::SUM_W-1:0] sum_sh;
  logic [N-1:0]              scaled_r, scaled_nxt;
  logic [P_W-1:0]            prod;
  logic [LW-1:0]             luma_r, luma_nxt;

  // stage 1: linearise each channel
  always_comb begin
    lin_r_nxt = tcs_pkg::LIN_TABLE[red];
    lin_g_nxt = tcs_pkg::LIN_TABLE[green];
    lin_b_nxt = tcs_pkg::LIN_TABLE[blue];
  end

  // stage 2: weighted sum, round and drop the power of two of the divisor
  always_comb begin
    sum = tcs_pkg::SUM_W'(lin_r_r) * tcs_pkg::SUM_W'(tcs_pkg::COEF_R)
        + tcs_pkg::SUM_W'(lin_g_r) * tcs_pkg::SUM_W'(tcs_pkg::COEF_G)
        + tcs_pkg::SUM_W'(lin_b_r) * tcs_pkg::SUM_W'(tcs_pkg::COEF_B);
    sum_sh = (sum + HALF) >> SHIFT;
    scaled_nxt = sum_sh[N-1:0];
  end

  // stage 3: exact floor divide by 625 through the reciprocal
  always_comb begin
    prod     = P_W'(scaled_r) * P_W'(RECIP[N:0]);
    luma_nxt = prod[S +: LW];
  end

  always_ff @(posedge clk) begin
    if (en.lookup) begin
      lin_r_r <= lin_r_nxt;
      lin_g_r <= lin_g_nxt;
      lin_b_r <= lin_b_nxt;
    end
    if (en.sum) begin
      scaled_r <= scaled_nxt;
    end
    if (en.scale) begin
      luma_r <= luma_nxt;
    end
  end

  assign luma = luma_r;

endmodule
